FILE: hdl/totpf_pkg.sv
package totpf_pkg;

  localparam int SWEEP_BITS = 32;

  localparam int CFG_INDEX_BITS = 1;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_THRESHOLD  = 1'b0;
  localparam cfg_index_t REG_MIN_LENGTH = 1'b1;

endpackage

FILE: hdl/time_over_threshold_pulse_finder.sv
// Channel   Direction  Beat content
// s_*       in         one waveform sample with its timestamp and sweep number
// m_*       out        one reported pulse: start, length, peak and sweep
// cfg_*     in         register write: threshold or minimum pulse length
//
// A sample enters an input register, is judged combinationally against the
// running pulse state, and a reported pulse lands in the output register.
// One sample per cycle is sustained while the output is not stalled; m_tvalid comes from the output register.
// Reset clears the pulse state, the config registers and all valid flags, not the data registers.
// A stalled output holds the pipe only while the input register is also full.
module time_over_threshold_pulse_finder #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 48,
  localparam int IN_RAW     = SAMPLE_BITS + TIME_BITS + totpf_pkg::SWEEP_BITS,
  localparam int IN_BITS    = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW    = 2 * TIME_BITS + SAMPLE_BITS + totpf_pkg::SWEEP_BITS,
  localparam int OUT_BITS   = ((OUT_RAW + 7) / 8) * 8,
  localparam int CFG_BITS   = (SAMPLE_BITS > TIME_BITS) ? SAMPLE_BITS : TIME_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_BITS-1:0]        s_tdata,   // sample, sample_time, sweep_index
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_BITS-1:0]       m_tdata,   // start_time, duration, peak_level, pulse_sweep
  input  logic                      cfg_we,
  input  totpf_pkg::cfg_index_t     cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data
);
  import totpf_pkg::*;

  logic signed [SAMPLE_BITS-1:0] threshold;
  logic [TIME_BITS-1:0]          min_length;

  logic                          in_valid;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [TIME_BITS-1:0]          in_time;
  logic [SWEEP_BITS-1:0]         in_sweep;

  logic                          out_free;
  logic                          step;
  logic                          hit;
  logic [TIME_BITS-1:0]          hit_start;
  logic [TIME_BITS-1:0]          hit_length;
  logic signed [SAMPLE_BITS-1:0] hit_peak;
  logic [SWEEP_BITS-1:0]         hit_sweep;

  logic [TIME_BITS-1:0]          out_start;
  logic [TIME_BITS-1:0]          out_length;
  logic signed [SAMPLE_BITS-1:0] out_peak;
  logic [SWEEP_BITS-1:0]         out_sweep;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= '0;
      min_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:  threshold  <= cfg_data[SAMPLE_BITS-1:0];
        REG_MIN_LENGTH: min_length <= cfg_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata[SAMPLE_BITS-1:0];
      in_time   <= s_tdata[SAMPLE_BITS +: TIME_BITS];
      in_sweep  <= s_tdata[SAMPLE_BITS + TIME_BITS +: SWEEP_BITS];
    end
  end

  totpf_track #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_track (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .sample           (in_sample),
    .sample_time      (in_time),
    .sweep_index      (in_sweep),
    .threshold        (threshold),
    .min_length       (min_length),
    .hit              (hit),
    .start_time       (hit_start),
    .duration         (hit_length),
    .peak_level       (hit_peak),
    .pulse_sweep      (hit_sweep)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (hit && out_free) begin
      out_start  <= hit_start;
      out_length <= hit_length;
      out_peak   <= hit_peak;
      out_sweep  <= hit_sweep;
    end
  end

  assign m_tdata = OUT_BITS'({out_sweep, out_peak, out_length, out_start});

  a_out_has_source: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $past(in_valid) || $past(m_tvalid && !m_tready))
    else $error("result appeared without a sample behind it");

  a_length_meets_min: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_length >= min_length)
    else $error("reported pulse shorter than the minimum length");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_free |=> in_valid && $stable(in_time))
    else $error("pending sample lost while the output was stalled");

endmodule

FILE: hdl/totpf_track.sv
module totpf_track #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  step,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  input  logic [TIME_BITS-1:0]                  sample_time,
  input  logic [totpf_pkg::SWEEP_BITS-1:0]      sweep_index,
  input  logic signed [SAMPLE_BITS-1:0]         threshold,
  input  logic [TIME_BITS-1:0]                  min_length,
  output logic                                  hit,
  output logic [TIME_BITS-1:0]                  start_time,
  output logic [TIME_BITS-1:0]                  duration,
  output logic signed [SAMPLE_BITS-1:0]         peak_level,
  output logic [totpf_pkg::SWEEP_BITS-1:0]      pulse_sweep
);
  import totpf_pkg::*;

  logic                          above_flag;
  logic [TIME_BITS-1:0]          rise_stamp;
  logic signed [SAMPLE_BITS-1:0] peak_value;

  logic                          over;
  logic                          rising;
  logic                          falling;
  logic [TIME_BITS:0]            diff;

  assign over    = sample >= threshold;
  assign rising  = over && !above_flag;
  assign falling = !over && above_flag;

  // The top bit of the difference is the borrow: set when time went backwards.
  assign diff = {1'b0, sample_time} - {1'b0, rise_stamp};

  assign hit          = step && falling && !diff[TIME_BITS] &&
                        (diff[TIME_BITS-1:0] >= min_length);
  assign start_time   = rise_stamp;
  assign duration     = diff[TIME_BITS-1:0];
  assign peak_level   = peak_value;
  assign pulse_sweep  = sweep_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      above_flag <= 1'b0;
    end else if (step) begin
      above_flag <= over;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_stamp <= '0;
      peak_value <= '0;
    end else if (step) begin
      if (rising) begin
        rise_stamp <= sample_time;
        peak_value <= sample;
      end else if (over && (sample > peak_value)) begin
        peak_value <= sample;
      end
    end
  end

endmodule
